// ----- hdl/abump_pkg.sv -----
// abump_pkg: shared types, constants and codes of the arena bump allocator
// no dependencies; used by abump_grow, abump_ctrl, the top level and the testbench
package abump_pkg;

	localparam int SIZE_BITS  = 40;
	localparam int MAX_ARENAS = 8;
	localparam int IDX_W      = $clog2(MAX_ARENAS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int CTR_W      = 32;
	localparam int GROWTH_W   = 16;
	localparam int ALIGN_W    = 4;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int PRESS_W    = 2;

	localparam logic [SIZE_BITS-1:0] SIZE_MASK = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC   = 3'd0,
		KIND_DEALLOC = 3'd1,
		KIND_RESET   = 3'd2,
		KIND_RESERVE = 3'd3,
		KIND_RELEASE = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALIGN   = 3'd0,
		CFG_GROW_EN = 3'd1,
		CFG_MAX     = 3'd2,
		CFG_INIT    = 3'd3,
		CFG_GROWTH  = 3'd4
	} cfg_idx_t;

	typedef enum logic [PRESS_W-1:0] {
		PRESS_NONE    = 2'd0,
		PRESS_REDUCE  = 2'd1,
		PRESS_OFFLOAD = 2'd2,
		PRESS_FAIL    = 2'd3
	} press_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RSV,
		ST_SCAN,
		ST_CMP,
		ST_GWAIT,
		ST_GROW,
		ST_CAP,
		ST_COMMIT,
		ST_FAIL,
		ST_CLEAR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ALIGN_W-1:0]   align;
		logic                 grow_en;
		logic [SIZE_BITS-1:0] pool_cap;
		logic [SIZE_BITS-1:0] init_size;
		logic [GROWTH_W-1:0]  growth;
	} cfg_t;

	typedef struct packed {
		logic                 cap_we;
		logic                 fill_we;
		logic [IDX_W-1:0]     waddr;
		logic [SIZE_BITS-1:0] cap_wdata;
		logic [SIZE_BITS-1:0] fill_wdata;
		logic                 re;
		logic [IDX_W-1:0]     raddr;
	} memreq_t;

	typedef struct packed {
		logic                 ok;
		logic [IDX_W-1:0]     arena_index;
		logic [SIZE_BITS-1:0] arena_offset;
		logic [PRESS_W-1:0]   pressure_action;
		logic [SIZE_BITS-1:0] total_bytes;
		logic [SIZE_BITS-1:0] used_bytes;
		logic [SIZE_BITS-1:0] free_bytes;
		logic [SIZE_BITS-1:0] peak_bytes;
		logic [CTR_W-1:0]     alloc_count;
		logic [CTR_W-1:0]     dealloc_count;
		logic [CTR_W-1:0]     reset_count;
	} res_t;

endpackage

// ----- hdl/abump_ram.sv -----
// abump_ram: generic synchronous ram, one write and one read port
// read data registered; no dependencies
module abump_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/abump_grow.sv -----
// abump_grow: two-stage growth product, total * growth_q8 / 256, saturated
// depends on abump_pkg
module abump_grow (
	input  logic                                clk,
	input  logic [abump_pkg::SIZE_BITS-1:0]     total,
	input  logic [abump_pkg::GROWTH_W-1:0]      growth,
	output logic [abump_pkg::SIZE_BITS-1:0]     grown_q
);

	localparam int HI_W   = abump_pkg::SIZE_BITS - 8;
	localparam int PROD_W = HI_W + abump_pkg::GROWTH_W;

	logic [PROD_W-1:0]               prod_s1;
	logic [abump_pkg::GROWTH_W-1:0]  lo_s1;
	logic [abump_pkg::GROWTH_W+7:0]  lo_full;
	logic [PROD_W:0]                 sum;

	// low byte product, shifted down when registered into lo_s1
	assign lo_full = total[7:0] * growth;
	assign sum     = {1'b0, prod_s1} + (PROD_W+1)'(lo_s1);

	always_ff @(posedge clk) begin
		prod_s1 <= total[abump_pkg::SIZE_BITS-1:8] * growth;
		lo_s1   <= lo_full[abump_pkg::GROWTH_W+7:8];
		if (|sum[PROD_W:abump_pkg::SIZE_BITS]) begin
			grown_q <= abump_pkg::SIZE_MASK;
		end else begin
			grown_q <= sum[abump_pkg::SIZE_BITS-1:0];
		end
	end

endmodule

// ----- hdl/abump_ctrl.sv -----
// abump_ctrl: command sequencer, first-fit scan, growth decision, pool statistics
// depends on abump_pkg; drives the capacity and fill rams through a memreq_t
module abump_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  abump_pkg::cfg_t                   cfg,
	input  logic                              start,
	input  logic [abump_pkg::KIND_W-1:0]      kind,
	input  logic [abump_pkg::SIZE_BITS-1:0]   size,
	output logic                              idle,
	output logic                              res_valid,
	input  logic                              res_ready,
	output abump_pkg::res_t                   res,
	output abump_pkg::memreq_t                mreq,
	input  logic [abump_pkg::SIZE_BITS-1:0]   cap_rd,
	input  logic [abump_pkg::SIZE_BITS-1:0]   fill_rd,
	input  logic [abump_pkg::SIZE_BITS-1:0]   grown
);

	localparam int SB = abump_pkg::SIZE_BITS;
	localparam int CW = abump_pkg::CNT_W;
	localparam int IW = abump_pkg::IDX_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(abump_pkg::MAX_ARENAS);

	abump_pkg::state_t state_q, state_d;

	logic [SB-1:0]    size_q, size_d, need_q, need_d, ns_q, ns_d;
	logic [SB-1:0]    total_q, total_d, used_q, used_d, peak_q, peak_d;
	logic [CW-1:0]    count_q, count_d, idx_q, idx_d;
	logic [abump_pkg::CTR_W-1:0] allocs_q, allocs_d, deallocs_q, deallocs_d;
	logic [abump_pkg::CTR_W-1:0] resets_q, resets_d;
	logic             r_ok_q, r_ok_d;
	logic [IW-1:0]    r_idx_q, r_idx_d;
	logic [SB-1:0]    r_off_q, r_off_d;
	logic [abump_pkg::PRESS_W-1:0] r_press_q, r_press_d;

	logic [SB-1:0]    amask, need_in, room, idx_room;
	logic             over_in, fit, last, can_grow, table_open;
	logic [SB+3:0]    ten_used, nine_total;

	function automatic logic [SB-1:0] SIZE_MASK_SHL(input logic [abump_pkg::ALIGN_W-1:0] a);
		SIZE_MASK_SHL = abump_pkg::SIZE_MASK << a;
	endfunction

	assign amask      = ~(SIZE_MASK_SHL(cfg.align));
	assign over_in    = size > (abump_pkg::SIZE_MASK - amask);
	assign need_in    = (size + amask) & ~amask;
	assign idx_room   = cap_rd - fill_rd;
	assign fit        = idx_room >= need_q;
	assign last       = (idx_q + CW'(1)) == count_q;
	assign table_open = count_q < MAX_CNT;
	assign room       = abump_pkg::SIZE_MASK - total_q;
	assign can_grow   = cfg.grow_en && table_open &&
		!((cfg.pool_cap != '0) && (total_q >= cfg.pool_cap));
	assign ten_used   = ({4'b0, used_q} << 3) + ({4'b0, used_q} << 1);
	assign nine_total = ({4'b0, total_q} << 3) + {4'b0, total_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			abump_pkg::ST_IDLE: begin
				if (start) begin
					case (kind)
						abump_pkg::KIND_ALLOC: begin
							if (over_in) state_d = abump_pkg::ST_FAIL;
							else if (count_q == '0) state_d = abump_pkg::ST_GWAIT;
							else state_d = abump_pkg::ST_SCAN;
						end
						abump_pkg::KIND_RESET: begin
							state_d = (count_q != '0) ? abump_pkg::ST_CLEAR : abump_pkg::ST_DONE;
						end
						abump_pkg::KIND_RESERVE: state_d = abump_pkg::ST_RSV;
						default: state_d = abump_pkg::ST_DONE;
					endcase
				end
			end
			abump_pkg::ST_RSV: begin
				state_d = ((total_q >= size_q) || table_open) ? abump_pkg::ST_DONE
					: abump_pkg::ST_FAIL;
			end
			abump_pkg::ST_SCAN: state_d = abump_pkg::ST_CMP;
			abump_pkg::ST_CMP: begin
				if (fit) state_d = abump_pkg::ST_DONE;
				else if (last) state_d = abump_pkg::ST_GWAIT;
			end
			abump_pkg::ST_GWAIT: state_d = can_grow ? abump_pkg::ST_GROW : abump_pkg::ST_FAIL;
			abump_pkg::ST_GROW: state_d = abump_pkg::ST_CAP;
			abump_pkg::ST_CAP: state_d = abump_pkg::ST_COMMIT;
			abump_pkg::ST_COMMIT: begin
				state_d = (ns_q >= need_q) ? abump_pkg::ST_DONE : abump_pkg::ST_FAIL;
			end
			abump_pkg::ST_FAIL: state_d = abump_pkg::ST_DONE;
			abump_pkg::ST_CLEAR: begin
				if (last) state_d = abump_pkg::ST_DONE;
			end
			abump_pkg::ST_DONE: begin
				if (res_ready) state_d = abump_pkg::ST_IDLE;
			end
			default: state_d = abump_pkg::ST_IDLE;
		endcase
	end

	// datapath and memory requests
	always_comb begin
		logic [SB-1:0] new_used;
		logic [SB-1:0] tmp;
		logic [SB-1:0] add;
		size_d     = size_q;
		need_d     = need_q;
		ns_d       = ns_q;
		total_d    = total_q;
		used_d     = used_q;
		peak_d     = peak_q;
		count_d    = count_q;
		idx_d      = idx_q;
		allocs_d   = allocs_q;
		deallocs_d = deallocs_q;
		resets_d   = resets_q;
		r_ok_d     = r_ok_q;
		r_idx_d    = r_idx_q;
		r_off_d    = r_off_q;
		r_press_d  = r_press_q;
		mreq       = '0;
		new_used   = used_q + need_q;
		add        = size_q - total_q;
		tmp        = ns_q;
		case (state_q)
			abump_pkg::ST_IDLE: begin
				if (start) begin
					r_ok_d    = 1'b0;
					r_idx_d   = '0;
					r_off_d   = '0;
					r_press_d = abump_pkg::PRESS_NONE;
					size_d    = size;
					idx_d     = '0;
					need_d    = over_in ? abump_pkg::SIZE_MASK : need_in;
					case (kind)
						abump_pkg::KIND_DEALLOC: begin
							deallocs_d = deallocs_q + 1'b1;
							r_ok_d     = 1'b1;
						end
						abump_pkg::KIND_RESET: begin
							used_d   = '0;
							resets_d = resets_q + 1'b1;
							r_ok_d   = 1'b1;
						end
						abump_pkg::KIND_RELEASE: begin
							count_d = '0;
							total_d = '0;
							used_d  = '0;
							r_ok_d  = 1'b1;
						end
						default: ;
					endcase
				end
			end
			abump_pkg::ST_RSV: begin
				if (total_q >= size_q) begin
					r_ok_d = 1'b1;
				end else if (table_open) begin
					mreq.cap_we     = 1'b1;
					mreq.fill_we    = 1'b1;
					mreq.waddr      = count_q[IW-1:0];
					mreq.cap_wdata  = add;
					mreq.fill_wdata = '0;
					count_d         = count_q + 1'b1;
					total_d         = total_q + add;
					r_ok_d          = 1'b1;
				end else begin
					need_d = add;
				end
			end
			abump_pkg::ST_SCAN: begin
				mreq.re    = 1'b1;
				mreq.raddr = idx_q[IW-1:0];
			end
			abump_pkg::ST_CMP: begin
				if (fit) begin
					mreq.fill_we    = 1'b1;
					mreq.waddr      = idx_q[IW-1:0];
					mreq.fill_wdata = fill_rd + need_q;
					used_d          = new_used;
					if (new_used > peak_q) peak_d = new_used;
					allocs_d        = allocs_q + 1'b1;
					r_ok_d          = 1'b1;
					r_idx_d         = idx_q[IW-1:0];
					r_off_d         = fill_rd;
				end else if (!last) begin
					idx_d      = idx_q + 1'b1;
					mreq.re    = 1'b1;
					mreq.raddr = idx_d[IW-1:0];
				end
			end
			abump_pkg::ST_GROW: begin
				if (count_q != '0) ns_d = (grown > need_q) ? grown : need_q;
				else ns_d = (cfg.init_size > need_q) ? cfg.init_size : need_q;
			end
			abump_pkg::ST_CAP: begin
				if ((cfg.pool_cap != '0) && (tmp > cfg.pool_cap - total_q)) begin
					tmp = cfg.pool_cap - total_q;
				end
				if (tmp > room) tmp = room;
				ns_d = tmp;
			end
			abump_pkg::ST_COMMIT: begin
				if (ns_q >= need_q) begin
					mreq.cap_we     = 1'b1;
					mreq.fill_we    = 1'b1;
					mreq.waddr      = count_q[IW-1:0];
					mreq.cap_wdata  = ns_q;
					mreq.fill_wdata = need_q;
					count_d         = count_q + 1'b1;
					total_d         = total_q + ns_q;
					used_d          = new_used;
					if (new_used > peak_q) peak_d = new_used;
					allocs_d        = allocs_q + 1'b1;
					r_ok_d          = 1'b1;
					r_idx_d         = count_q[IW-1:0];
					r_off_d         = '0;
				end
			end
			abump_pkg::ST_FAIL: begin
				if (need_q > total_q) r_press_d = abump_pkg::PRESS_REDUCE;
				else if (ten_used > nine_total) r_press_d = abump_pkg::PRESS_OFFLOAD;
				else r_press_d = abump_pkg::PRESS_FAIL;
			end
			abump_pkg::ST_CLEAR: begin
				mreq.fill_we    = 1'b1;
				mreq.waddr      = idx_q[IW-1:0];
				mreq.fill_wdata = '0;
				idx_d           = idx_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign idle      = (state_q == abump_pkg::ST_IDLE);
	assign res_valid = (state_q == abump_pkg::ST_DONE);

	always_comb begin
		res.ok              = r_ok_q;
		res.arena_index     = r_idx_q;
		res.arena_offset    = r_off_q;
		res.pressure_action = r_press_q;
		res.total_bytes     = total_q;
		res.used_bytes      = used_q;
		res.free_bytes      = total_q - used_q;
		res.peak_bytes      = peak_q;
		res.alloc_count     = allocs_q;
		res.dealloc_count   = deallocs_q;
		res.reset_count     = resets_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= abump_pkg::ST_IDLE;
			count_q    <= '0;
			total_q    <= '0;
			used_q     <= '0;
			peak_q     <= '0;
			allocs_q   <= '0;
			deallocs_q <= '0;
			resets_q   <= '0;
			idx_q      <= '0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			total_q    <= total_d;
			used_q     <= used_d;
			peak_q     <= peak_d;
			allocs_q   <= allocs_d;
			deallocs_q <= deallocs_d;
			resets_q   <= resets_d;
			idx_q      <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		size_q    <= size_d;
		need_q    <= need_d;
		ns_q      <= ns_d;
		r_ok_q    <= r_ok_d;
		r_idx_q   <= r_idx_d;
		r_off_q   <= r_off_d;
		r_press_q <= r_press_d;
	end

endmodule

// ----- hdl/arena_bump_allocator_unit.sv -----
// arena bump allocator, one transaction in flight; result held in an output register
// deallocate, release and unknown kinds go straight to the result; reset first clears
// each arena's fill offset; reserve fails only when the table is full; allocate scans the
// arenas first-fit, and on a miss grows, caps and commits a new arena (no scan on an empty
// table); next command taken once the result enters the output register (out_stall holds it)
// arena rams are not cleared by reset; counters, pool statistics and configuration registers reset
module arena_bump_allocator_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [abump_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [abump_pkg::SIZE_BITS-1:0]       cfg_data,
	// command channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [abump_pkg::KIND_W-1:0]          kind,
	input  logic [abump_pkg::SIZE_BITS-1:0]       size,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  ok,
	output logic [abump_pkg::IDX_W-1:0]           arena_index,
	output logic [abump_pkg::SIZE_BITS-1:0]       arena_offset,
	output logic [abump_pkg::PRESS_W-1:0]         pressure_action,
	output logic [abump_pkg::SIZE_BITS-1:0]       total_bytes,
	output logic [abump_pkg::SIZE_BITS-1:0]       used_bytes,
	output logic [abump_pkg::SIZE_BITS-1:0]       free_bytes,
	output logic [abump_pkg::SIZE_BITS-1:0]       peak_bytes,
	output logic [abump_pkg::CTR_W-1:0]           alloc_count,
	output logic [abump_pkg::CTR_W-1:0]           dealloc_count,
	output logic [abump_pkg::CTR_W-1:0]           reset_count
);

	abump_pkg::cfg_t     cfg_q;
	abump_pkg::memreq_t  mreq;
	abump_pkg::res_t     res, res_q;
	logic                idle, res_valid, res_ready, out_valid_q;
	logic [abump_pkg::SIZE_BITS-1:0] cap_rd, fill_rd, grown;

	// configuration registers; the user must write them only while idle (unenforced by the block)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.align     <= abump_pkg::ALIGN_W'(8);
			cfg_q.grow_en   <= 1'b1;
			cfg_q.pool_cap  <= '0;
			cfg_q.init_size <= '0;
			cfg_q.growth    <= abump_pkg::GROWTH_W'(512);
		end else if (cfg_we) begin
			case (cfg_index)
				abump_pkg::CFG_ALIGN:   cfg_q.align     <= cfg_data[abump_pkg::ALIGN_W-1:0];
				abump_pkg::CFG_GROW_EN: cfg_q.grow_en   <= cfg_data[0];
				abump_pkg::CFG_MAX:     cfg_q.pool_cap  <= cfg_data;
				abump_pkg::CFG_INIT:    cfg_q.init_size <= cfg_data;
				abump_pkg::CFG_GROWTH:  cfg_q.growth    <= cfg_data[abump_pkg::GROWTH_W-1:0];
				default: ;
			endcase
		end
	end

	// a new command is taken only when the sequencer is back in idle
	assign in_stall = !idle;

	abump_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (in_valid),
		.kind      (kind),
		.size      (size),
		.idle      (idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mreq      (mreq),
		.cap_rd    (cap_rd),
		.fill_rd   (fill_rd),
		.grown     (grown)
	);

	// per-arena capacity
	abump_ram #(
		.WIDTH (abump_pkg::SIZE_BITS),
		.DEPTH (abump_pkg::MAX_ARENAS)
	) u_cap_ram (
		.clk   (clk),
		.we    (mreq.cap_we),
		.waddr (mreq.waddr),
		.wdata (mreq.cap_wdata),
		.re    (mreq.re),
		.raddr (mreq.raddr),
		.rdata (cap_rd)
	);

	// per-arena fill offset
	abump_ram #(
		.WIDTH (abump_pkg::SIZE_BITS),
		.DEPTH (abump_pkg::MAX_ARENAS)
	) u_fill_ram (
		.clk   (clk),
		.we    (mreq.fill_we),
		.waddr (mreq.waddr),
		.wdata (mreq.fill_wdata),
		.re    (mreq.re),
		.raddr (mreq.raddr),
		.rdata (fill_rd)
	);

	// growth product tracks the pool total, settled long before it is used
	abump_grow u_grow (
		.clk     (clk),
		.total   (res.total_bytes),
		.growth  (cfg_q.growth),
		.grown_q (grown)
	);

	// output register: free when empty or when the held transaction leaves
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign ok              = res_q.ok;
	assign arena_index     = res_q.arena_index;
	assign arena_offset    = res_q.arena_offset;
	assign pressure_action = res_q.pressure_action;
	assign total_bytes     = res_q.total_bytes;
	assign used_bytes      = res_q.used_bytes;
	assign free_bytes      = res_q.free_bytes;
	assign peak_bytes      = res_q.peak_bytes;
	assign alloc_count     = res_q.alloc_count;
	assign dealloc_count   = res_q.dealloc_count;
	assign reset_count     = res_q.reset_count;

endmodule

// ----- tb/tb.sv -----
// tb: self-checking testbench of arena_bump_allocator_unit
// depends on hdl/abump_pkg.sv and the block's top level
`timescale 1ns / 1ps

module tb;

	localparam int SB = abump_pkg::SIZE_BITS;
	localparam int KW = abump_pkg::KIND_W;
	localparam int IW = abump_pkg::IDX_W;
	localparam logic [KW-1:0] KIND_BAD_LO  = 3'd5;
	localparam logic [KW-1:0] KIND_BAD_MID = 3'd6;
	localparam logic [KW-1:0] KIND_BAD_HI  = 3'd7;
	localparam logic [63:0] FULL = 64'(abump_pkg::SIZE_MASK);
	localparam int STALL_PCT = 17;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [abump_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [SB-1:0] cfg_data;
	logic in_valid, in_stall;
	logic [KW-1:0] kind;
	logic [SB-1:0] size;
	logic out_valid, out_stall;
	abump_pkg::res_t got;

	// clock: 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	arena_bump_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .size(size),
		.out_valid(out_valid), .out_stall(out_stall),
		.ok(got.ok), .arena_index(got.arena_index), .arena_offset(got.arena_offset),
		.pressure_action(got.pressure_action), .total_bytes(got.total_bytes),
		.used_bytes(got.used_bytes), .free_bytes(got.free_bytes),
		.peak_bytes(got.peak_bytes), .alloc_count(got.alloc_count),
		.dealloc_count(got.dealloc_count), .reset_count(got.reset_count)
	);

	// shadow copy of the allocator: arena table, pool figures and registers
	logic [63:0] sh_cap [abump_pkg::MAX_ARENAS];
	logic [63:0] sh_fill [abump_pkg::MAX_ARENAS];
	int unsigned sh_count;
	logic [63:0] sh_total, sh_used, sh_free, sh_peak;
	logic [31:0] sh_allocs, sh_deallocs, sh_resets;
	logic [3:0] sh_align;
	logic sh_grow_en;
	logic [63:0] sh_max, sh_init;
	logic [15:0] sh_growth;

	abump_pkg::res_t pending_results [$];
	bit idling_on = 1'b1;
	int mismatches = 0;
	int quiet_cycles = 0;

	// pressure class for a failed request of need bytes
	function automatic abump_pkg::press_t pressure_for(logic [63:0] need);
		logic [63:0] nine_tenths;
		nine_tenths = sh_total - (sh_total / 10 + ((sh_total % 10) != 0 ? 1 : 0));
		if (need > sh_total) return abump_pkg::PRESS_REDUCE;
		if (sh_used > nine_tenths) return abump_pkg::PRESS_OFFLOAD;
		return abump_pkg::PRESS_FAIL;
	endfunction

	// total * growth / 256, saturating at the size width
	function automatic logic [63:0] grown_capacity();
		logic [63:0] hi, lo, prod;
		hi = sh_total >> 8;
		lo = ((sh_total & 64'd255) * 64'(sh_growth)) >> 8;
		if (hi != 0 && 64'(sh_growth) > FULL / hi) return FULL;
		prod = hi * 64'(sh_growth);
		if (prod > FULL - lo) return FULL;
		return prod + lo;
	endfunction

	function automatic void book_alloc(int unsigned idx, logic [63:0] amount);
		sh_fill[idx] += amount;
		sh_used += amount;
		sh_free -= amount;
		sh_allocs++;
		if (sh_used > sh_peak) sh_peak = sh_used;
	endfunction

	// works out the result of one command and updates the shadow state
	function automatic void predict_command(logic [KW-1:0] k, logic [SB-1:0] s);
		abump_pkg::res_t r;
		logic [63:0] amask, need, ns, room, g, add, req;
		bit over, placed;
		r = '0;
		req = 64'(s);
		placed = 1'b0;
		case (k)
			abump_pkg::KIND_ALLOC: begin
				amask = (64'd1 << sh_align) - 1;
				over = req > FULL - amask;
				need = over ? FULL : ((req + amask) & ~amask);
				if (!over) begin
					for (int i = 0; i < sh_count; i++) begin
						if (!placed && sh_cap[i] - sh_fill[i] >= need) begin
							r.arena_index = i[IW-1:0];
							r.arena_offset = sh_fill[i][SB-1:0];
							book_alloc(i, need);
							placed = 1'b1;
						end
					end
				end
				if (placed) begin
					r.ok = 1'b1;
				end else if (!over && sh_grow_en && sh_count < abump_pkg::MAX_ARENAS &&
						!(sh_max != 0 && sh_total >= sh_max)) begin
					ns = need;
					room = FULL - sh_total;
					if (sh_count != 0) begin
						g = grown_capacity();
						if (g > ns) ns = g;
					end else if (sh_init > ns) begin
						ns = sh_init;
					end
					if (sh_max != 0 && ns > sh_max - sh_total) ns = sh_max - sh_total;
					if (ns > room) ns = room;
					if (ns >= need) begin
						r.arena_index = sh_count[IW-1:0];
						sh_cap[sh_count] = ns;
						sh_fill[sh_count] = 0;
						sh_total += ns;
						sh_free += ns;
						book_alloc(sh_count, need);
						sh_count++;
						r.ok = 1'b1;
					end else begin
						r.pressure_action = pressure_for(need);
					end
				end else begin
					r.pressure_action = pressure_for(need);
				end
			end
			abump_pkg::KIND_DEALLOC: begin
				sh_deallocs++;
				r.ok = 1'b1;
			end
			abump_pkg::KIND_RESET: begin
				for (int i = 0; i < sh_count; i++) sh_fill[i] = 0;
				sh_used = 0;
				sh_free = sh_total;
				sh_resets++;
				r.ok = 1'b1;
			end
			abump_pkg::KIND_RESERVE: begin
				if (sh_total >= req) begin
					r.ok = 1'b1;
				end else begin
					add = req - sh_total;
					if (sh_count < abump_pkg::MAX_ARENAS) begin
						sh_cap[sh_count] = add;
						sh_fill[sh_count] = 0;
						sh_count++;
						sh_total += add;
						sh_free += add;
						r.ok = 1'b1;
					end else begin
						r.pressure_action = pressure_for(add);
					end
				end
			end
			abump_pkg::KIND_RELEASE: begin
				sh_count = 0;
				sh_total = 0;
				sh_used = 0;
				sh_free = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.total_bytes = sh_total[SB-1:0];
		r.used_bytes = sh_used[SB-1:0];
		r.free_bytes = sh_free[SB-1:0];
		r.peak_bytes = sh_peak[SB-1:0];
		r.alloc_count = sh_allocs;
		r.dealloc_count = sh_deallocs;
		r.reset_count = sh_resets;
		pending_results.insert(pending_results.size(), r);
	endfunction

	// names the fields that differ
	function automatic string differing_fields(abump_pkg::res_t e, abump_pkg::res_t a);
		string d;
		d = "";
		if (e.ok !== a.ok) d = {d, " ok"};
		if (e.arena_index !== a.arena_index) d = {d, " arena_index"};
		if (e.arena_offset !== a.arena_offset) d = {d, " arena_offset"};
		if (e.pressure_action !== a.pressure_action) d = {d, " pressure_action"};
		if (e.total_bytes !== a.total_bytes) d = {d, " total_bytes"};
		if (e.used_bytes !== a.used_bytes) d = {d, " used_bytes"};
		if (e.free_bytes !== a.free_bytes) d = {d, " free_bytes"};
		if (e.peak_bytes !== a.peak_bytes) d = {d, " peak_bytes"};
		if (e.alloc_count !== a.alloc_count) d = {d, " alloc_count"};
		if (e.dealloc_count !== a.dealloc_count) d = {d, " dealloc_count"};
		if (e.reset_count !== a.reset_count) d = {d, " reset_count"};
		return d;
	endfunction

	// result checker: every accepted result against the oldest prediction
	always @(posedge clk) begin
		abump_pkg::res_t e;
		string d;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction at %0t: %p", $realtime, got);
			end else begin
				e = pending_results.pop_front();
				d = differing_fields(e, got);
				if (d != "") begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t in%s\n  expected %p\n  actual   %p",
							$realtime, d, e, got);
				end
			end
		end
	end

	// result side back-pressure on about 17 percent of cycles, while idling is on
	always @(posedge clk) begin
		out_stall <= idling_on && ($urandom_range(99) < STALL_PCT);
	end

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", pending_results.size());
			$display("** arena_bump_allocator_unit: FAILED **");
			$finish;
		end
	end

	// one command transaction; valid stays high into the next call unless a gap is taken
	task automatic send_command(logic [KW-1:0] k, logic [SB-1:0] s);
		while (idling_on && $urandom_range(99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		size <= s;
		predict_command(k, s);
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// drop valid and wait until every prediction has been matched
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write enable stays high across back-to-back writes; the caller drops it
	task automatic write_register(abump_pkg::cfg_idx_t idx, logic [SB-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			abump_pkg::CFG_ALIGN: sh_align = v[3:0];
			abump_pkg::CFG_GROW_EN: sh_grow_en = v[0];
			abump_pkg::CFG_MAX: sh_max = 64'(v);
			abump_pkg::CFG_INIT: sh_init = 64'(v);
			abump_pkg::CFG_GROWTH: sh_growth = v[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [3:0] al, logic gr, logic [SB-1:0] mx,
			logic [SB-1:0] ini, logic [15:0] gq);
		write_register(abump_pkg::CFG_ALIGN, SB'(al));
		write_register(abump_pkg::CFG_GROW_EN, SB'(gr));
		write_register(abump_pkg::CFG_MAX, mx);
		write_register(abump_pkg::CFG_INIT, ini);
		write_register(abump_pkg::CFG_GROWTH, SB'(gq));
		cfg_we <= 1'b0;
	endtask

	// reset defaults, zero sizes, every kind including unknown ones, alignment overflow
	task automatic test_basic_commands();
		send_command(abump_pkg::KIND_ALLOC, '0);
		send_command(abump_pkg::KIND_ALLOC, 40'd1);
		send_command(abump_pkg::KIND_ALLOC, 40'd300);
		send_command(abump_pkg::KIND_DEALLOC, '0);
		send_command(abump_pkg::KIND_RESET, '0);
		send_command(abump_pkg::KIND_ALLOC, 40'd256);
		send_command(abump_pkg::KIND_RESERVE, 40'd10);
		send_command(abump_pkg::KIND_RESERVE, 40'd100000);
		send_command(KIND_BAD_LO, 40'd5);
		send_command(KIND_BAD_MID, abump_pkg::SIZE_MASK);
		send_command(KIND_BAD_HI, 40'd7);
		send_command(abump_pkg::KIND_ALLOC, abump_pkg::SIZE_MASK);
		send_command(abump_pkg::KIND_RELEASE, '0);
		drain();
		// empty pool with a zero initial arena
		set_config(4'd0, 1'b1, '0, '0, 16'd512);
		send_command(abump_pkg::KIND_ALLOC, '0);
		send_command(abump_pkg::KIND_ALLOC, '0);
		send_command(abump_pkg::KIND_ALLOC, 40'd1);
		send_command(abump_pkg::KIND_RELEASE, '0);
		drain();
	endtask

	// fill the arena table, then allocate and reserve beyond it
	task automatic test_table_full();
		set_config(4'd4, 1'b1, '0, 40'd64, 16'd0);
		for (int i = 1; i <= abump_pkg::MAX_ARENAS; i++)
			send_command(abump_pkg::KIND_RESERVE, SB'(i * 1000));
		send_command(abump_pkg::KIND_RESERVE, 40'd20000);
		send_command(abump_pkg::KIND_ALLOC, 40'd5000);
		send_command(abump_pkg::KIND_ALLOC, 40'd100);
		send_command(abump_pkg::KIND_RELEASE, '0);
		drain();
	endtask

	// growth disabled, pool cap, capped arena too small, total near the size limit
	task automatic test_growth_limits();
		set_config(4'd0, 1'b0, '0, '0, 16'd256);
		send_command(abump_pkg::KIND_ALLOC, 40'd8);
		send_command(abump_pkg::KIND_RESERVE, 40'd16);
		send_command(abump_pkg::KIND_ALLOC, 40'd16);
		send_command(abump_pkg::KIND_ALLOC, 40'd1);
		send_command(abump_pkg::KIND_RELEASE, '0);
		drain();
		set_config(4'd12, 1'b1, 40'd10000, 40'd6000, 16'hffff);
		send_command(abump_pkg::KIND_ALLOC, 40'd1);
		send_command(abump_pkg::KIND_ALLOC, 40'd4096);
		send_command(abump_pkg::KIND_ALLOC, 40'd4096);
		send_command(abump_pkg::KIND_ALLOC, 40'd4096);
		send_command(abump_pkg::KIND_RESET, '0);
		send_command(abump_pkg::KIND_RELEASE, '0);
		drain();
		set_config(4'd15, 1'b1, abump_pkg::SIZE_MASK, abump_pkg::SIZE_MASK, 16'hffff);
		send_command(abump_pkg::KIND_ALLOC, 40'd1);
		send_command(abump_pkg::KIND_ALLOC, 40'd1);
		send_command(abump_pkg::KIND_RELEASE, '0);
		drain();
		set_config(4'd0, 1'b1, '0, '0, 16'hffff);
		send_command(abump_pkg::KIND_RESERVE, abump_pkg::SIZE_MASK - 40'd10);
		send_command(abump_pkg::KIND_ALLOC, 40'd100);
		send_command(abump_pkg::KIND_ALLOC, 40'd5);
		send_command(abump_pkg::KIND_RESERVE, abump_pkg::SIZE_MASK);
		send_command(abump_pkg::KIND_RELEASE, '0);
		drain();
	endtask

	function automatic logic [SB-1:0] random_size();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70) return SB'($urandom_range(4096));
		if (pick < 85) return SB'($urandom_range(1 << 24));
		return SB'({$urandom, $urandom});
	endfunction

	// mixed traffic, mostly allocations, with resets and releases to keep arenas turning over
	task automatic test_random_traffic(int items);
		int unsigned pick;
		logic [KW-1:0] k;
		logic [SB-1:0] s;
		for (int n = 0; n < items; n++) begin
			pick = $urandom_range(99);
			s = random_size();
			if (pick < 55) k = abump_pkg::KIND_ALLOC;
			else if (pick < 63) k = abump_pkg::KIND_DEALLOC;
			else if (pick < 74) k = abump_pkg::KIND_RESET;
			else if (pick < 85) begin
				k = abump_pkg::KIND_RESERVE;
				if ($urandom_range(1)) s = sh_total[SB-1:0] + SB'($urandom_range(8192));
			end else if (pick < 95) k = abump_pkg::KIND_RELEASE;
			else k = KIND_BAD_LO + KW'($urandom_range(2));
			send_command(k, s);
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		kind <= '0;
		size <= '0;
		out_stall <= 1'b0;
		sh_count = 0;
		sh_total = 0; sh_used = 0; sh_free = 0; sh_peak = 0;
		sh_allocs = 0; sh_deallocs = 0; sh_resets = 0;
		sh_align = 4'd8; sh_grow_en = 1'b1; sh_max = 0; sh_init = 0; sh_growth = 16'd512;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_commands();
		test_table_full();
		test_growth_limits();

		set_config(4'd3, 1'b1, '0, 40'd2048, 16'd384);
		test_random_traffic(400);
		// long stretch with neither side idling
		idling_on = 1'b0;
		set_config(4'd0, 1'b1, 40'd5000000, '0, 16'd256);
		test_random_traffic(400);
		idling_on = 1'b1;
		set_config(4'd12, 1'b1, abump_pkg::SIZE_MASK, abump_pkg::SIZE_MASK, 16'hffff);
		test_random_traffic(300);
		set_config(4'd6, 1'b0, '0, 40'd100, 16'd0);
		test_random_traffic(300);
		set_config(4'd1, 1'b1, 40'd65536, 40'd1024, 16'd640);
		test_random_traffic(600);

		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("** arena_bump_allocator_unit: PASSED **");
		else
			$display("** arena_bump_allocator_unit: FAILED **");
		$finish;
	end

endmodule
